// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the checker in bmhq_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heap queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heap queue assertion failed");

`endif

// ----- rtl/bmhq_pkg.sv -----
package bmhq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int PRIO_W     = 16;
    localparam int PAYLOAD_W  = 32;
    localparam int COUNT_W    = 9;
    localparam int OP_W       = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    typedef logic signed [PRIO_W-1:0] t_prio;

    typedef struct packed {
        t_prio                prio;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        t_prio                key_priority;
        logic [PAYLOAD_W-1:0] payload_tag;
    } t_cmd;

    typedef struct packed {
        t_prio                out_priority;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 found;
        logic                 push_dropped;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT_CAP,
        S_DN_RD,
        S_DN_SEL,
        S_DN_CMP
    } t_state;

endpackage

// ----- rtl/bmhq_ram.sv -----
module bmhq_ram #(
    parameter int DEPTH = bmhq_pkg::HEAP_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  bmhq_pkg::t_entry  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output bmhq_pkg::t_entry  o_rd_data_a,
    output bmhq_pkg::t_entry  o_rd_data_b
);
    import bmhq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- rtl/bmhq_cmp.sv -----
module bmhq_cmp (
    input  bmhq_pkg::t_prio i_a,
    input  bmhq_pkg::t_prio i_b,
    output logic            o_lt
);
    import bmhq_pkg::*;

    // Both operands are signed, so this is a two's complement compare.
    assign o_lt = (i_a < i_b);

endmodule

// ----- rtl/binary_min_heap_queue_unit.sv -----
// Bounded binary min-heap priority queue. Each word on i_cmd is a push, a pop of the
// smallest priority or a peek at it; it is taken on a clock edge with start high and
// busy low, and exactly one result word follows on o_result, marked by o_done for a
// single cycle. The receiver cannot stall: o_result is valid only while o_done is high.
// Heap entries live in a two-read, one-write RAM, and all priority compares go through
// one shared comparator, so the cost is set by the RAM read latency per heap level.
// A push reads the parent and compares it per level (S_UP_RD, S_UP_CMP) until the new
// entry reaches the root or a compare stops it. A pop reads the root and the last entry
// (S_ROOT_RD, S_ROOT_CAP), then sinks the moved entry per level by reading both
// children, picking the smaller and comparing it (S_DN_RD, S_DN_SEL, S_DN_CMP) until it
// reaches the bottom or a compare stops it. A peek only reads and captures the root.
// A push on a full heap, a pop or peek on an empty heap and the unused op code
// answer on the cycle after acceptance. The next word may be started in the cycle
// o_done is high. No clearing pass is needed after reset.
module binary_min_heap_queue_unit #(
    parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bmhq_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_done,
    output bmhq_pkg::t_result o_result
);
    import bmhq_pkg::*;

    // The entry count must fit the result's count field, so HEAP_DEPTH stays below 512.
    localparam int SLOT_W = $clog2(HEAP_DEPTH + 1);
    localparam int ADDR_W = $clog2(HEAP_DEPTH);
    localparam logic [SLOT_W-1:0] FULL_SLOTS = SLOT_W'(HEAP_DEPTH);
    localparam logic [SLOT_W-1:0] ONE_SLOT   = SLOT_W'(1);

    t_state            r_state, n_state;
    logic              r_done, n_done;
    logic              r_is_pop, n_is_pop;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_last, n_last;
    logic [SLOT_W-1:0] r_n, n_n;
    logic [SLOT_W-1:0] r_m, n_m;
    t_entry            r_key, n_key;
    t_entry            r_child, n_child;
    t_result           r_res, n_res;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    t_entry            rd_a;
    t_entry            rd_b;
    t_prio             cmp_a;
    t_prio             cmp_b;
    logic              cmp_lt;
    logic [SLOT_W:0]   dn_m;
    logic              dn_stop;
    logic              right_ok;

    bmhq_ram #(
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    bmhq_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    // Slots are numbered from one; RAM word zero holds slot one.
    assign dn_m     = {r_n, 1'b0};
    assign dn_stop  = (dn_m >= {1'b0, r_last});
    assign right_ok = (({1'b0, r_m} + {{SLOT_W{1'b0}}, 1'b1}) < {1'b0, r_last});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_pop <= n_is_pop;
        r_last   <= n_last;
        r_n      <= n_n;
        r_m      <= n_m;
        r_key    <= n_key;
        r_child  <= n_child;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_is_pop  = r_is_pop;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_n       = r_n;
        n_m       = r_m;
        n_key     = r_key;
        n_child   = r_child;
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_addr   = ADDR_W'(r_n - ONE_SLOT);
        wr_data   = r_key;
        rd_addr_a = '0;
        rd_addr_b = '0;
        cmp_a     = r_key.prio;
        cmp_b     = rd_a.prio;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res             = '0;
                    n_res.entry_count = COUNT_W'(r_cnt);
                    case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_cnt == FULL_SLOTS) begin
                                n_res.push_dropped = 1'b1;
                                n_done             = 1'b1;
                            end else begin
                                n_key.prio    = i_cmd.key_priority;
                                n_key.payload = i_cmd.payload_tag;
                                n_n           = r_cnt + ONE_SLOT;
                                n_cnt         = r_cnt + ONE_SLOT;
                                n_state       = S_UP_RD;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_cnt == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_is_pop = (i_cmd.op == OP_POP);
                                n_state  = S_ROOT_RD;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_UP_RD: begin
                if (r_n == ONE_SLOT) begin
                    wr_en             = 1'b1;
                    n_res.entry_count = COUNT_W'(r_cnt);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    rd_addr_a = ADDR_W'((r_n >> 1) - ONE_SLOT);
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                // The parent moves down while the new entry is strictly smaller.
                wr_en = 1'b1;
                if (cmp_lt) begin
                    wr_data = rd_a;
                    n_n     = r_n >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_res.entry_count = COUNT_W'(r_cnt);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_ROOT_RD: begin
                rd_addr_a = ADDR_W'(ONE_SLOT - ONE_SLOT);
                rd_addr_b = ADDR_W'(r_cnt - ONE_SLOT);
                n_state   = S_ROOT_CAP;
            end

            S_ROOT_CAP: begin
                n_res.out_priority = rd_a.prio;
                n_res.out_payload  = rd_a.payload;
                n_res.found        = 1'b1;
                if (!r_is_pop) begin
                    n_res.entry_count = COUNT_W'(r_cnt);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_key   = rd_b;
                    n_last  = r_cnt;
                    n_cnt   = r_cnt - ONE_SLOT;
                    n_n     = ONE_SLOT;
                    n_state = S_DN_RD;
                end
            end

            S_DN_RD: begin
                if (dn_stop) begin
                    wr_en             = 1'b1;
                    n_res.entry_count = COUNT_W'(r_cnt);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    // Both children are fetched at once; the right one is ignored
                    // when it lies past the last entry.
                    rd_addr_a = ADDR_W'(SLOT_W'(dn_m) - ONE_SLOT);
                    rd_addr_b = ADDR_W'(SLOT_W'(dn_m));
                    n_m       = SLOT_W'(dn_m);
                    n_state   = S_DN_SEL;
                end
            end

            S_DN_SEL: begin
                // On a tie the left child is kept.
                cmp_a = rd_b.prio;
                cmp_b = rd_a.prio;
                if (right_ok && cmp_lt) begin
                    n_child = rd_b;
                    n_m     = r_m + ONE_SLOT;
                end else begin
                    n_child = rd_a;
                end
                n_state = S_DN_CMP;
            end

            S_DN_CMP: begin
                cmp_a = r_child.prio;
                cmp_b = r_key.prio;
                wr_en = 1'b1;
                if (cmp_lt) begin
                    wr_data = r_child;
                    n_n     = r_m;
                    n_state = S_DN_RD;
                end else begin
                    n_res.entry_count = COUNT_W'(r_cnt);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- rtl/bmhq_chk.sv -----
`include "assert_macros.svh"

module bmhq_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input bmhq_pkg::t_result o_result
);
    import bmhq_pkg::*;

    logic accepted;

    assign accepted = start && !busy;

    // Every accepted word either keeps the unit working or answers at once.
    `BMHQ_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accepted, busy || o_done)

    // A result only appears after an accepted word or at the end of a busy spell.
    `BMHQ_ASSERT_NOW(a_done_cause, i_clk, i_rst_n, o_done, $past(accepted) || $past(busy))

    // Leaving the busy state always delivers the result word.
    `BMHQ_ASSERT_NOW(a_done_on_fall, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_done)

    `BMHQ_ASSERT_NOW(a_found_excl, i_clk, i_rst_n, o_done, !(o_result.found && o_result.push_dropped))

    `BMHQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_done, o_result.entry_count <= COUNT_W'(HEAP_DEPTH))

endmodule

bind binary_min_heap_queue_unit bmhq_chk u_bmhq_chk (.*);

// ----- tb/tb_top.sv -----
module tb_top;
    import bmhq_pkg::*;

    // The package names no code for the unused op; it must act as a no-op.
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int LIMIT_TIME = 5_000_000;

    typedef struct {
        t_cmd cmd;
        int   gap;
        bit   drain;
    } t_pending;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    cmd_word = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    binary_min_heap_queue_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd_word),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow heap that the expected results are computed from.
    t_prio       model_prio [1:HEAP_DEPTH];
    logic [31:0] model_tag  [1:HEAP_DEPTH];
    int          model_fill = 0;

    t_pending pending_words[$];
    t_result  expected_results[$];

    int err_count = 0;
    int words_sent = 0;
    int total_words = 0;
    int results_seen = 0;
    int n_push_ok = 0, n_dropped = 0, n_pop_hit = 0, n_peek_hit = 0;
    int n_empty = 0, n_noop = 0, peak_fill = 0;

    // Generator state.
    int    gen_fill = 0;
    int    quiet_left = 0;
    int    prio_style = 0;
    t_prio ramp_prio = '0;
    bit    drain_next = 1'b0;

    function automatic t_result heap_predict(t_cmd c);
        t_result     r;
        t_prio       moved_p;
        logic [31:0] moved_t;
        int          n, m, last;
        r = '0;
        case (c.op)
            OP_PUSH: begin
                if (model_fill >= HEAP_DEPTH) begin
                    r.push_dropped = 1'b1;
                    n_dropped++;
                end else begin
                    n = model_fill + 1;
                    model_fill = n;
                    moved_p = c.key_priority;
                    while (n > 1 && moved_p < model_prio[n/2]) begin
                        model_prio[n] = model_prio[n/2];
                        model_tag[n]  = model_tag[n/2];
                        n = n / 2;
                    end
                    model_prio[n] = moved_p;
                    model_tag[n]  = c.payload_tag;
                    n_push_ok++;
                    if (model_fill > peak_fill) peak_fill = model_fill;
                end
            end
            OP_POP, OP_PEEK: begin
                if (model_fill == 0) begin
                    n_empty++;
                end else begin
                    r.found = 1'b1;
                    r.out_priority = model_prio[1];
                    r.out_payload  = model_tag[1];
                    if (c.op == OP_PEEK) begin
                        n_peek_hit++;
                    end else begin
                        n_pop_hit++;
                        last = model_fill;
                        model_fill = last - 1;
                        moved_p = model_prio[last];
                        moved_t = model_tag[last];
                        n = 1;
                        m = 2;
                        // Walk the last entry down, taking the left child on a tie.
                        while (m < last) begin
                            if (m + 1 < last && model_prio[m] > model_prio[m+1]) m++;
                            if (moved_p <= model_prio[m]) break;
                            model_prio[n] = model_prio[m];
                            model_tag[n]  = model_tag[m];
                            n = m;
                            m = 2 * n;
                        end
                        model_prio[n] = moved_p;
                        model_tag[n]  = moved_t;
                    end
                end
            end
            default: begin
                n_noop++;
            end
        endcase
        r.entry_count = COUNT_W'(model_fill);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want_val);
        if (err_count < 100)
            $display("MISMATCH t=%0t result %0d %s: got %0h, expected %0h",
                     $time, results_seen, field, got, want_val);
        err_count++;
    endtask

    task automatic queue_word(logic [OP_W-1:0] op, t_prio prio, logic [31:0] tag);
        t_pending it;
        it.cmd.op = op;
        it.cmd.key_priority = prio;
        it.cmd.payload_tag = tag;
        it.drain = drain_next || ($urandom_range(0, 59) == 0);
        drain_next = 1'b0;
        if (quiet_left > 0) begin
            quiet_left--;
            it.gap = 0;
        end else begin
            it.gap = $urandom_range(0, 14);
            if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(10, 30);
        end
        if (op == OP_PUSH && gen_fill < HEAP_DEPTH) gen_fill++;
        if (op == OP_POP && gen_fill > 0) gen_fill--;
        pending_words.push_back(it);
    endtask

    function automatic t_prio draw_prio();
        case (prio_style)
            0: return t_prio'($urandom);
            1: return t_prio'($urandom_range(0, 8) - 4);  // narrow range, many ties
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            3: begin
                ramp_prio = ramp_prio + t_prio'($urandom_range(0, 3));
                return ramp_prio;
            end
            default: begin
                ramp_prio = ramp_prio - t_prio'($urandom_range(0, 3));
                return ramp_prio;
            end
        endcase
    endfunction

    task automatic queue_random(int push_w, int pop_w);
        int              r;
        logic [OP_W-1:0] op;
        if ((pending_words.size() % 40) == 0) prio_style = $urandom_range(0, 4);
        r = $urandom_range(0, 99);
        if (r < push_w) op = OP_PUSH;
        else if (r < push_w + pop_w) op = OP_POP;
        else if (r < 96) op = OP_PEEK;
        else op = OP_NONE;
        queue_word(op, draw_prio(), $urandom);
    endtask

    // Driver: a word is taken at an edge with start high and busy low.
    t_pending next_word;
    int       hold_left = 0;
    bit       word_ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(heap_predict(cmd_word));
                words_sent++;
            end
            if (!start || !busy) begin
                if (!word_ready && pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    hold_left = next_word.gap;
                    word_ready = 1'b1;
                end
                if (word_ready && hold_left == 0 &&
                    (!next_word.drain || expected_results.size() == 0)) begin
                    start <= 1'b1;
                    cmd_word <= next_word.cmd;
                    word_ready = 1'b0;
                end else begin
                    start <= 1'b0;
                    if (word_ready && hold_left > 0) hold_left--;
                end
            end
        end
    end

    // Monitor: every o_done word is checked against the oldest expectation.
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("word with nothing outstanding", 64'(o_result), '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.out_priority !== want.out_priority)
                    report_mismatch("out_priority", 64'(o_result.out_priority),
                                    64'(want.out_priority));
                if (o_result.out_payload !== want.out_payload)
                    report_mismatch("out_payload", 64'(o_result.out_payload),
                                    64'(want.out_payload));
                if (o_result.found !== want.found)
                    report_mismatch("found", 64'(o_result.found), 64'(want.found));
                if (o_result.push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", 64'(o_result.push_dropped),
                                    64'(want.push_dropped));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_result.entry_count),
                                    64'(want.entry_count));
            end
            results_seen++;
        end
    end

    initial begin
        // Directed: empty heap, unused op, extreme priorities and tags, ties.
        queue_word(OP_POP, '0, '0);
        queue_word(OP_PEEK, '0, '0);
        queue_word(OP_NONE, -16'sd1, 32'hFFFF_FFFF);
        queue_word(OP_PUSH, 16'sh7FFF, 32'hFFFF_FFFF);
        queue_word(OP_PUSH, 16'sh8000, 32'h0000_0000);
        queue_word(OP_PUSH, 16'sh0000, 32'h0000_0001);
        queue_word(OP_PUSH, 16'sh8000, 32'h0000_0002);
        queue_word(OP_PUSH, -16'sd1, 32'hA5A5_5A5A);
        queue_word(OP_PUSH, 16'sd1, 32'h5A5A_A5A5);
        queue_word(OP_PUSH, 16'sh7FFF, 32'h0000_0003);
        queue_word(OP_PEEK, 16'sh7FFF, 32'hFFFF_FFFF);
        queue_word(OP_NONE, 16'sh7FFF, 32'h1234_5678);
        repeat (8) queue_word(OP_POP, '0, '0);
        queue_word(OP_PEEK, 16'sh8000, 32'hFFFF_FFFF);
        queue_word(OP_NONE, '0, '0);

        drain_next = 1'b1;
        repeat (80) queue_random(45, 35);

        // Fill to capacity, then push into a full heap.
        drain_next = 1'b1;
        while (gen_fill < HEAP_DEPTH) queue_random(88, 6);
        repeat (8) queue_random(95, 0);

        // Empty it again, then poke the empty heap.
        drain_next = 1'b1;
        while (gen_fill > 0) queue_random(5, 85);
        repeat (5) queue_random(0, 60);

        drain_next = 1'b1;
        repeat (40) queue_random(50, 35);
        total_words = pending_words.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < total_words || expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d words: %0d pushes stored, %0d refused when full, %0d pops, %0d peeks.",
                 total_words, n_push_ok, n_dropped, n_pop_hit, n_peek_hit);
        $display("%0d pop/peek on empty, %0d unused-op words, peak fill %0d of %0d.",
                 n_empty, n_noop, peak_fill, HEAP_DEPTH);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Run timed out with %0d of %0d words sent, %0d results outstanding.",
                 words_sent, total_words, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- binary_min_heap_queue_unit.f -----
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_cmp.sv
rtl/binary_min_heap_queue_unit.sv
rtl/bmhq_chk.sv
tb/tb_top.sv
